### hdl/float_cube_root_core_defines.svh
// Assertion macros shared by the cube root RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef FLOAT_CUBE_ROOT_CORE_DEFINES_SVH
`define FLOAT_CUBE_ROOT_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define FCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define FCR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hdl/fcr_pkg.sv
// Shared constants, the sideband type and the round-and-pack function of the cube root core.
// No dependencies.
package fcr_pkg;

    localparam int EXP_W       = 12;
    localparam int FMA_LAT     = 6;
    localparam int DIV_STEPS   = 26;
    localparam int DIV_LAT     = DIV_STEPS + 2;
    localparam int SEED_LAT    = 2;
    localparam int RECIP_STEPS = 2;
    localparam int PIPE_LAT    = 2 + FMA_LAT + SEED_LAT
                                 + RECIP_STEPS * (6 * FMA_LAT + DIV_LAT)
                                 + (3 * FMA_LAT + DIV_LAT);

    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
    localparam logic [30:0] BIAS_NORM    = 31'd709958130;
    localparam logic [30:0] BIAS_SUB     = 31'd642849266;
    localparam logic [31:0] RECIP3_MAGIC = 32'hAAAA_AAAB;
    localparam logic [31:0] F_ZERO       = 32'h0000_0000;
    localparam logic [31:0] F_ONE        = 32'h3F80_0000;
    localparam logic [31:0] F_TWO        = 32'h4000_0000;
    localparam logic [31:0] F_THIRD      = 32'h3EAA_AAAB;
    localparam logic [31:0] F_SCALE24    = 32'h4B80_0000;

    localparam logic signed [EXP_W-1:0] EXP_NIL  = 0;
    localparam logic signed [EXP_W-1:0] EXP_ONE  = 1;
    localparam logic signed [EXP_W-1:0] EXP_BIAS = 127;
    localparam logic signed [EXP_W-1:0] EXP_TOP  = 255;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_bits;
        logic [31:0] x;
        logic [31:0] t;
        logic [31:0] aux;
    } side_t;

    function automatic logic [31:0] fp_round(
        input logic                    sgn,
        input logic signed [EXP_W-1:0] expo,
        input logic [23:0]             man,
        input logic                    rnd,
        input logic                    stk
    );
        logic                    inc;
        logic [24:0]             msum;
        logic signed [EXP_W-1:0] e_r;
        logic [22:0]             frac;
        logic [31:0]             res;
        inc  = rnd & (stk | man[0]);
        msum = {1'b0, man} + {24'd0, inc};
        e_r  = msum[24] ? expo + EXP_ONE : expo;
        frac = msum[24] ? 23'd0 : msum[22:0];
        if (e_r >= EXP_TOP)
        begin
            res = {sgn, 8'hff, 23'd0};
        end
        else if (e_r <= EXP_NIL)
        begin
            res = {sgn, 31'd0};
        end
        else
        begin
            res = {sgn, e_r[7:0], frac};
        end
        return res;
    endfunction

endpackage

### hdl/float_cube_root_core.sv
// Binary32 cube root: accepts one transaction per clock and returns the results in order.
// The pipeline is a chain of 16 six-stage multiply-add units and three 28-stage dividers for
// the scaling and Newton steps, plus input, seed and output registers. busy never rises, so a
// transaction may be started in every cycle. Each result appears on root_bits for one cycle
// with done high; the receiver must take it then. Zeros and infinities pass unchanged, NaNs
// come back quieted. Depends on fcr_pkg, fcr_fma, fcr_div and float_cube_root_core_defines.svh.
`include "float_cube_root_core_defines.svh"

module float_cube_root_core import fcr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] operand_bits,
    output logic        done,
    output logic [31:0] root_bits
);

    assign busy = 1'b0;

    // input register
    logic        in_valid_reg;
    logic [31:0] x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= operand_bits;
    end

    side_t in_side;

    always_comb
    begin
        in_side           = '0;
        in_side.x         = x_reg;
        in_side.spec      = (x_reg[30:23] == 8'hff) || (x_reg[30:0] == 31'd0);
        in_side.spec_bits = ((x_reg[30:23] == 8'hff) && (x_reg[22:0] != 23'd0))
                            ? (x_reg | QUIET_BIT) : x_reg;
    end

    // scale subnormals by 2^24
    logic        sc_v;
    logic [31:0] sc_y;
    side_t       sc_side;

    fcr_fma u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .a        (x_reg),
        .b        (F_SCALE24),
        .c        (F_ZERO),
        .in_side  (in_side),
        .out_valid(sc_v),
        .y        (sc_y),
        .out_side (sc_side)
    );

    // seed: magnitude word over three plus bias
    logic        sub_in, sub_reg, va_reg, vb_reg;
    logic [31:0] hx;
    logic [63:0] prod_next;
    logic [30:0] quot_reg;
    side_t       side_a_reg, side_b_reg, side_b_next;

    always_comb
    begin
        sub_in    = (sc_side.x[30:23] == 8'd0);
        hx        = sub_in ? {1'b0, sc_y[30:0]} : {1'b0, sc_side.x[30:0]};
        prod_next = {32'd0, hx} * {32'd0, RECIP3_MAGIC};
    end

    always_comb
    begin
        side_b_next   = side_a_reg;
        side_b_next.t = {side_a_reg.x[31], quot_reg + (sub_reg ? BIAS_SUB : BIAS_NORM)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= sc_v;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg   <= prod_next[63:33];
        sub_reg    <= sub_in;
        side_a_reg <= sc_side;
        side_b_reg <= side_b_next;
    end

    // Newton steps with refined reciprocal
    logic  step_v    [RECIP_STEPS+1];
    side_t step_side [RECIP_STEPS+1];

    assign step_v[0]    = vb_reg;
    assign step_side[0] = side_b_reg;

    for (genvar k = 0; k < RECIP_STEPS; k++)
    begin : g_recip
        logic        tt_v, r_v, e_v, r2_v, q_v, d_v, tn_v;
        logic [31:0] tt_y, r_y, e_y, r2_y, q_y, d_y, tn_y;
        side_t       tt_s, r_s, e_s, r2_s, q_s, d_s, tn_s;
        side_t       dv_in, f1_in, nx_side;

        always_comb
        begin
            dv_in     = tt_s;
            dv_in.aux = tt_y;
            f1_in     = r_s;
            f1_in.aux = r_y;
            nx_side   = tn_s;
            nx_side.t = tn_y;
        end

        fcr_fma u_sq (
            .clk(clk), .rst_n(rst_n), .in_valid(step_v[k]),
            .a(step_side[k].t), .b(step_side[k].t), .c(F_ZERO), .in_side(step_side[k]),
            .out_valid(tt_v), .y(tt_y), .out_side(tt_s)
        );

        fcr_div u_rcp (
            .clk(clk), .rst_n(rst_n), .in_valid(tt_v),
            .a(F_ONE), .b(tt_y), .in_side(dv_in),
            .out_valid(r_v), .y(r_y), .out_side(r_s)
        );

        fcr_fma u_err (
            .clk(clk), .rst_n(rst_n), .in_valid(r_v),
            .a({~r_s.aux[31], r_s.aux[30:0]}), .b(r_y), .c(F_TWO), .in_side(f1_in),
            .out_valid(e_v), .y(e_y), .out_side(e_s)
        );

        fcr_fma u_fix (
            .clk(clk), .rst_n(rst_n), .in_valid(e_v),
            .a(e_s.aux), .b(e_y), .c(F_ZERO), .in_side(e_s),
            .out_valid(r2_v), .y(r2_y), .out_side(r2_s)
        );

        fcr_fma u_quo (
            .clk(clk), .rst_n(rst_n), .in_valid(r2_v),
            .a(r2_s.x), .b(r2_y), .c(F_ZERO), .in_side(r2_s),
            .out_valid(q_v), .y(q_y), .out_side(q_s)
        );

        fcr_fma u_dif (
            .clk(clk), .rst_n(rst_n), .in_valid(q_v),
            .a(q_y), .b(F_ONE), .c({~q_s.t[31], q_s.t[30:0]}), .in_side(q_s),
            .out_valid(d_v), .y(d_y), .out_side(d_s)
        );

        fcr_fma u_upd (
            .clk(clk), .rst_n(rst_n), .in_valid(d_v),
            .a(d_y), .b(F_THIRD), .c(d_s.t), .in_side(d_s),
            .out_valid(tn_v), .y(tn_y), .out_side(tn_s)
        );

        assign step_v[k+1]    = tn_v;
        assign step_side[k+1] = nx_side;
    end

    // final Newton step with true division
    logic        ft_v, fq_v, fd_v, fn_v;
    logic [31:0] ft_y, fq_y, fd_y, fn_y;
    side_t       ft_s, fq_s, fd_s, fn_s;

    fcr_fma u_fsq (
        .clk(clk), .rst_n(rst_n), .in_valid(step_v[RECIP_STEPS]),
        .a(step_side[RECIP_STEPS].t), .b(step_side[RECIP_STEPS].t), .c(F_ZERO),
        .in_side(step_side[RECIP_STEPS]),
        .out_valid(ft_v), .y(ft_y), .out_side(ft_s)
    );

    fcr_div u_fdiv (
        .clk(clk), .rst_n(rst_n), .in_valid(ft_v),
        .a(ft_s.x), .b(ft_y), .in_side(ft_s),
        .out_valid(fq_v), .y(fq_y), .out_side(fq_s)
    );

    fcr_fma u_fdif (
        .clk(clk), .rst_n(rst_n), .in_valid(fq_v),
        .a(fq_y), .b(F_ONE), .c({~fq_s.t[31], fq_s.t[30:0]}), .in_side(fq_s),
        .out_valid(fd_v), .y(fd_y), .out_side(fd_s)
    );

    fcr_fma u_fupd (
        .clk(clk), .rst_n(rst_n), .in_valid(fd_v),
        .a(fd_y), .b(F_THIRD), .c(fd_s.t), .in_side(fd_s),
        .out_valid(fn_v), .y(fn_y), .out_side(fn_s)
    );

    // output register
    logic        done_reg;
    logic [31:0] root_next, root_reg;

    assign root_next = fn_s.spec ? fn_s.spec_bits : fn_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fn_v;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
    end

    assign done      = done_reg;
    assign root_bits = root_reg;

    `FCR_ASSERT_IMP(a_done_lat, done, $past(start && !busy, PIPE_LAT), "done without a started transaction")
    `FCR_ASSERT_IMP(a_zero_pass, done && $past(operand_bits[30:0] == 31'd0, PIPE_LAT), root_bits == $past(operand_bits, PIPE_LAT), "zero operand not returned unchanged")
    `FCR_ASSERT_IMP(a_nan_quiet, done && $past(operand_bits[30:23] == 8'hff && operand_bits[22:0] != 23'd0, PIPE_LAT), root_bits[30:22] == 9'h1ff, "NaN operand not returned quiet")
    `FCR_ASSERT_NEVER(a_sign_kept, done && (root_bits[31] != $past(operand_bits[31], PIPE_LAT)), "root sign differs from operand sign")

endmodule

### hdl/fcr_fma.sv
// Six-stage binary32 fused multiply-add, a*b+c rounded once to nearest even.
// Depends on fcr_pkg; carries a side_t word along with each transaction.
module fcr_fma import fcr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] y,
    output side_t       out_side
);

    localparam logic signed [EXP_W-1:0] PROD_OFS = 300;
    localparam logic signed [EXP_W-1:0] ADD_OFS  = 174;
    localparam logic signed [EXP_W-1:0] GRS_OFS  = 3;
    localparam logic signed [EXP_W-1:0] NORM_OFS = 178;
    localparam logic signed [EXP_W-1:0] SH_MAX   = 52;

    function automatic logic [5:0] lzc52(input logic [51:0] v);
        logic [5:0] n;
        n = 6'd52;
        for (int i = 0; i < 52; i++)
        begin
            if (v[i])
            begin
                n = 6'(51 - i);
            end
        end
        return n;
    endfunction

    logic [FMA_LAT-1:0] valid_reg;
    side_t              side_reg [FMA_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FMA_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < FMA_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // multiply
    logic [7:0]              ea, eb, ec, eae, ebe, ece;
    logic [23:0]             ma, mb, mc;
    logic [47:0]             prod_next, prod_reg;
    logic signed [EXP_W-1:0] ep_next, ep_reg, ecl_next, ecl_reg;
    logic [23:0]             mc_reg;
    logic                    sp_reg, sc_reg;

    always_comb
    begin
        ea        = a[30:23];
        eb        = b[30:23];
        ec        = c[30:23];
        eae       = (ea == 8'd0) ? 8'd1 : ea;
        ebe       = (eb == 8'd0) ? 8'd1 : eb;
        ece       = (ec == 8'd0) ? 8'd1 : ec;
        ma        = {|ea, a[22:0]};
        mb        = {|eb, b[22:0]};
        mc        = {|ec, c[22:0]};
        prod_next = {24'd0, ma} * {24'd0, mb};
        ep_next   = $signed({4'd0, eae}) + $signed({4'd0, ebe}) - PROD_OFS;
        ecl_next  = $signed({4'd0, ece}) - ADD_OFS;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        ep_reg   <= ep_next;
        ecl_reg  <= ecl_next;
        mc_reg   <= mc;
        sp_reg   <= a[31] ^ b[31];
        sc_reg   <= c[31];
    end

    // align
    logic                    pz, cz, take_p, sl_next, ss_next;
    logic [47:0]             lm, sm;
    logic signed [EXP_W-1:0] diff, dabs, el, elsb_next, elsb_reg;
    logic [5:0]              sh;
    logic [101:0]            shifted;
    logic [50:0]             lal_next, sal_next, lal_reg, sal_reg;
    logic                    sl_reg, ss_reg;

    always_comb
    begin
        pz        = (prod_reg == 48'd0);
        cz        = (mc_reg == 24'd0);
        take_p    = cz | (!pz & (ep_reg >= ecl_reg));
        diff      = ep_reg - ecl_reg;
        dabs      = take_p ? diff : -diff;
        lm        = take_p ? prod_reg : {mc_reg, 24'd0};
        sm        = take_p ? (cz ? 48'd0 : {mc_reg, 24'd0}) : prod_reg;
        el        = take_p ? ep_reg : ecl_reg;
        sl_next   = take_p ? sp_reg : sc_reg;
        ss_next   = take_p ? sc_reg : sp_reg;
        sh        = (dabs < EXP_NIL || dabs > SH_MAX) ? SH_MAX[5:0] : dabs[5:0];
        shifted   = {sm, 3'b000, 51'd0} >> sh;
        sal_next  = shifted[101:51] | {50'd0, |shifted[50:0]};
        lal_next  = {lm, 3'b000};
        elsb_next = el - GRS_OFS;
    end

    always_ff @(posedge clk)
    begin
        lal_reg  <= lal_next;
        sal_reg  <= sal_next;
        sl_reg   <= sl_next;
        ss_reg   <= ss_next;
        elsb_reg <= elsb_next;
    end

    // add
    logic [51:0]             sum_next, sum_reg;
    logic                    sg3_next, sg3_reg;
    logic signed [EXP_W-1:0] e3_reg;

    always_comb
    begin
        if (sl_reg == ss_reg)
        begin
            sum_next = {1'b0, lal_reg} + {1'b0, sal_reg};
            sg3_next = sl_reg;
        end
        else if (lal_reg >= sal_reg)
        begin
            sum_next = {1'b0, lal_reg} - {1'b0, sal_reg};
            sg3_next = sl_reg;
        end
        else
        begin
            sum_next = {1'b0, sal_reg} - {1'b0, lal_reg};
            sg3_next = ss_reg;
        end
        if (sum_next == 52'd0)
        begin
            sg3_next = sl_reg & ss_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        sg3_reg <= sg3_next;
        e3_reg  <= elsb_reg;
    end

    // count leading zeros
    logic [51:0]             sum4_reg;
    logic [5:0]              lz_next, lz_reg;
    logic                    sg4_reg;
    logic signed [EXP_W-1:0] e4_reg;

    assign lz_next = lzc52(sum_reg);

    always_ff @(posedge clk)
    begin
        sum4_reg <= sum_reg;
        lz_reg   <= lz_next;
        sg4_reg  <= sg3_reg;
        e4_reg   <= e3_reg;
    end

    // normalize
    logic [51:0]             norm_next, norm_reg;
    logic signed [EXP_W-1:0] e5_next, e5_reg;
    logic                    zero5_reg, sg5_reg;

    assign norm_next = sum4_reg << lz_reg;
    assign e5_next   = e4_reg + NORM_OFS - $signed({6'd0, lz_reg});

    always_ff @(posedge clk)
    begin
        norm_reg  <= norm_next;
        e5_reg    <= e5_next;
        zero5_reg <= (sum4_reg == 52'd0);
        sg5_reg   <= sg4_reg;
    end

    // round
    logic [31:0] y_next, y_reg;

    assign y_next = zero5_reg ? {sg5_reg, 31'd0}
                              : fp_round(sg5_reg, e5_reg, norm_reg[51:28], norm_reg[27],
                                         |norm_reg[26:0]);

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign out_valid = valid_reg[FMA_LAT-1];
    assign out_side  = side_reg[FMA_LAT-1];
    assign y         = y_reg;

endmodule

### hdl/fcr_div.sv
// Binary32 divider a/b, one restoring quotient bit per stage, rounded to nearest even.
// Depends on fcr_pkg; carries a side_t word along with each transaction.
module fcr_div import fcr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] y,
    output side_t       out_side
);

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    logic [DIV_LAT-1:0] valid_reg;
    side_t              side_reg [DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // unpack and normalize dividend
    logic [7:0]              ea, eb, eae, ebe;
    logic [23:0]             ma, man;
    logic [4:0]              lz;
    logic signed [EXP_W-1:0] e0_next;

    always_comb
    begin
        ea      = a[30:23];
        eb      = b[30:23];
        eae     = (ea == 8'd0) ? 8'd1 : ea;
        ebe     = (eb == 8'd0) ? 8'd1 : eb;
        ma      = {|ea, a[22:0]};
        lz      = lzc24(ma);
        man     = ma << lz;
        e0_next = $signed({4'd0, eae}) - $signed({7'd0, lz}) - $signed({4'd0, ebe})
                  + EXP_BIAS;
    end

    logic [25:0]             rem_reg [DIV_STEPS+1];
    logic [25:0]             q_reg   [DIV_STEPS+1];
    logic [23:0]             mb_reg  [DIV_STEPS+1];
    logic signed [EXP_W-1:0] e_reg   [DIV_STEPS+1];
    logic                    sg_reg  [DIV_STEPS+1];
    logic [25:0]             rem_next [DIV_STEPS];
    logic                    bit_next [DIV_STEPS];

    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            bit_next[k] = (rem_reg[k] >= {2'b00, mb_reg[k]});
            rem_next[k] = bit_next[k] ? rem_reg[k] - {2'b00, mb_reg[k]} : rem_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {2'b00, man};
        q_reg[0]   <= '0;
        mb_reg[0]  <= {|eb, b[22:0]};
        e_reg[0]   <= e0_next;
        sg_reg[0]  <= a[31] ^ b[31];
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            rem_reg[k+1] <= {rem_next[k][24:0], 1'b0};
            q_reg[k+1]   <= {q_reg[k][24:0], bit_next[k]};
            mb_reg[k+1]  <= mb_reg[k];
            e_reg[k+1]   <= e_reg[k];
            sg_reg[k+1]  <= sg_reg[k];
        end
    end

    // round
    logic [25:0]             qf;
    logic                    rem_nz;
    logic [31:0]             y_next, y_reg;

    always_comb
    begin
        qf     = q_reg[DIV_STEPS];
        rem_nz = (rem_reg[DIV_STEPS] != 26'd0);
        if (qf[25])
        begin
            y_next = fp_round(sg_reg[DIV_STEPS], e_reg[DIV_STEPS], qf[25:2], qf[1],
                              qf[0] | rem_nz);
        end
        else
        begin
            y_next = fp_round(sg_reg[DIV_STEPS], e_reg[DIV_STEPS] - EXP_ONE, qf[24:1], qf[0],
                              rem_nz);
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign out_valid = valid_reg[DIV_LAT-1];
    assign out_side  = side_reg[DIV_LAT-1];
    assign y         = y_reg;

endmodule
